>>> rtl/bfh_pkg.sv
// shared types, codes and defaults for the byte fifo with hold and release
`default_nettype none

package bfh_pkg;

    localparam int BFH_DEPTH     = 256;
    localparam int BFH_MAX_BURST = 64;
    localparam int PTR_W         = 8;
    localparam int LEN_W         = 9;
    localparam int HELD_W        = 9;

    typedef enum logic [2:0] {
        MODE_WRITE  = 3'd0,
        MODE_COPY   = 3'd1,
        MODE_HOLD   = 3'd2,
        MODE_RETURN = 3'd3,
        MODE_PEEK   = 3'd4
    } bfh_mode_t;

    typedef enum logic [2:0] {
        STAT_OK    = 3'd0,
        STAT_FULL  = 3'd1,
        STAT_ORDER = 3'd2,
        STAT_CLAMP = 3'd3,
        STAT_UNDER = 3'd4
    } bfh_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } bfh_state_t;

    typedef struct packed {
        logic [2:0]       mode;
        logic [7:0]       write_data;
        logic [LEN_W-1:0] length;
        logic [7:0]       offset;
    } bfh_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] grant_count;
        logic [7:0] region_start;
        logic [7:0] free_count;
        logic [7:0] unread_count;
        logic [2:0] status;
        logic       last;
    } bfh_rsp_t;

    // pointer state seen by the sequencer
    typedef struct packed {
        logic             wr_en;
        logic [PTR_W-1:0] wr_ptr;
        logic [PTR_W-1:0] rd_ptr;
        logic [LEN_W-1:0] ring_len;
        logic [7:0]       burst;
    } bfh_stat_t;

endpackage

`default_nettype wire

>>> rtl/byte_fifo_with_hold_release.sv
// Byte ring fifo with copy read, in-place hold and release, and peek.
// Every command gives its first result in the cycle after start is taken.
// Write, hold read, hold return, peek and unused modes give one result and leave busy low.
// A copy read of n bytes streams n results on consecutive cycles and keeps busy
// high until the last result appears, one byte per cycle from the single read port of the store.
// Reset clears pointers and held count at once, ring length min(DEPTH,256), free count one less; no clearing pass.
`default_nettype none

module byte_fifo_with_hold_release #(
    parameter int DEPTH     = bfh_pkg::BFH_DEPTH,
    parameter int MAX_BURST = bfh_pkg::BFH_MAX_BURST
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire bfh_pkg::bfh_req_t         req,
    output logic                           strobe,
    output bfh_pkg::bfh_rsp_t              rsp,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [bfh_pkg::LEN_W-1:0] cfg_data
);

    import bfh_pkg::*;

    localparam int MEM_DEPTH = (DEPTH < 256) ? DEPTH : 256;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int CNT_W     = $clog2(MAX_BURST + 1);

    bfh_state_t       state_reg, state_next;
    bfh_rsp_t         rsp_reg, rsp_next;
    logic             strobe_reg, strobe_next;
    logic             sel_reg, sel_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;

    bfh_rsp_t         core_rsp;
    bfh_stat_t        stat;
    logic             accept;
    logic             cfg_we;
    logic             copy_go;
    logic             peek_hit;
    logic [PTR_W-1:0] ptr_base;
    logic [LEN_W-1:0] ptr_sum;
    logic [PTR_W-1:0] ptr_inc;
    logic [PTR_W-1:0] raddr_full;
    logic [7:0]       ram_rdata;

    assign busy      = (state_reg == ST_COPY);
    assign accept    = start && !busy;
    // a size write waits until the fifo is not busy and no command is being offered
    assign cfg_ready = !busy && !start;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign copy_go   = (req.mode == MODE_COPY) && (stat.burst != '0);
    assign peek_hit  = (int'(req.offset) < DEPTH);

    bfh_core #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .rsp_next (core_rsp),
        .stat     (stat)
    );

    // copy read address walks the ring one byte per cycle
    assign ptr_base = busy ? rd_ptr_reg : stat.rd_ptr;
    assign ptr_sum  = {1'b0, ptr_base} + LEN_W'(1);
    assign ptr_inc  = (ptr_sum >= stat.ring_len) ? '0 : ptr_sum[PTR_W-1:0];

    always_comb
    begin
        if (busy)
        begin
            raddr_full = rd_ptr_reg;
        end
        else if (req.mode == MODE_COPY)
        begin
            raddr_full = stat.rd_ptr;
        end
        else
        begin
            raddr_full = req.offset;
        end
    end

    bfh_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (accept && stat.wr_en),
        .waddr (stat.wr_ptr[AW-1:0]),
        .wdata (req.write_data),
        .raddr (raddr_full[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        strobe_next = 1'b0;
        sel_next    = 1'b0;
        rsp_next    = rsp_reg;
        left_next   = left_reg;
        rd_ptr_next = rd_ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    strobe_next = 1'b1;
                    rsp_next    = core_rsp;
                    if (copy_go)
                    begin
                        sel_next      = 1'b1;
                        rsp_next.last = (stat.burst == 8'd1);
                        left_next     = CNT_W'(stat.burst - 8'd1);
                        rd_ptr_next   = ptr_inc;
                        if (stat.burst != 8'd1)
                        begin
                            state_next = ST_COPY;
                        end
                    end
                    else if (req.mode == MODE_PEEK)
                    begin
                        sel_next = peek_hit;
                    end
                end
            end
            ST_COPY:
            begin
                strobe_next   = 1'b1;
                sel_next      = 1'b1;
                rd_ptr_next   = ptr_inc;
                left_next     = left_reg - CNT_W'(1);
                rsp_next.last = (left_reg == CNT_W'(1));
                if (left_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            sel_reg    <= 1'b0;
            left_reg   <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            sel_reg    <= sel_next;
            left_reg   <= left_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        rsp           = rsp_reg;
        rsp.read_data = sel_reg ? ram_rdata : '0;
    end

    assign strobe = strobe_reg;

`ifndef SYNTHESIS
    a_copy_streams: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (strobe && !rsp.last))
        else $error("copy stream result missing or marked last too early");

    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !rsp.last) |=> strobe)
        else $error("gap inside a copy read burst");

    a_rd_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> ({1'b0, rd_ptr_reg} < stat.ring_len))
        else $error("copy read address outside the ring");

    a_idle_store_read: assert property (@(posedge clk) disable iff (!rst_n)
        (sel_reg && !busy && !$past(busy)) |-> $past(accept))
        else $error("store data shown without a transfer");
`endif

endmodule

`default_nettype wire

>>> rtl/bfh_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module bfh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/bfh_core.sv
// pointer registers and per-command state update of the ring
`default_nettype none

module bfh_core #(
    parameter int DEPTH     = bfh_pkg::BFH_DEPTH,
    parameter int MAX_BURST = bfh_pkg::BFH_MAX_BURST
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire bfh_pkg::bfh_req_t       req,
    input  wire logic                    cfg_we,
    input  wire logic [bfh_pkg::LEN_W-1:0] cfg_data,
    output bfh_pkg::bfh_rsp_t            rsp_next,
    output bfh_pkg::bfh_stat_t           stat
);

    import bfh_pkg::*;

    localparam int CAP = (DEPTH < 256) ? DEPTH : 256;
    localparam logic [LEN_W-1:0] S_MAX     = LEN_W'(CAP);
    localparam logic [LEN_W-1:0] S_MIN     = LEN_W'(2);
    localparam logic [LEN_W-1:0] BURST_MAX = LEN_W'(MAX_BURST);
    localparam logic [HELD_W:0]  HELD_SAT  = {1'b0, {HELD_W{1'b1}}};

    logic [LEN_W-1:0]  s_reg;
    logic [PTR_W-1:0]  w_reg, w_next;
    logic [PTR_W-1:0]  u_reg, u_next;
    logic [PTR_W-1:0]  h_reg, h_next;
    logic [7:0]        free_reg, free_next;
    logic [HELD_W-1:0] held_reg, held_next;

    logic [LEN_W-1:0]  s_cfg;
    logic [7:0]        s_m1;
    logic [7:0]        unread_cur;
    logic [7:0]        unread_next;
    logic              wr_en;
    logic [7:0]        burst;

    function automatic logic [7:0] unread_of(input logic [PTR_W-1:0] w,
                                             input logic [PTR_W-1:0] u,
                                             input logic [LEN_W-1:0] s);
        logic [LEN_W-1:0] diff;
        begin
            if (w >= u)
            begin
                diff = {1'b0, w} - {1'b0, u};
            end
            else
            begin
                diff = s - ({1'b0, u} - {1'b0, w});
            end
            return diff[7:0];
        end
    endfunction

    assign s_m1       = 8'(s_reg - LEN_W'(1));
    assign unread_cur = unread_of(w_reg, u_reg, s_reg);

    // ring length saturated into the usable range
    always_comb
    begin
        if (cfg_data < S_MIN)
        begin
            s_cfg = S_MIN;
        end
        else if (cfg_data > S_MAX)
        begin
            s_cfg = S_MAX;
        end
        else
        begin
            s_cfg = cfg_data;
        end
    end

    always_comb
    begin
        logic [LEN_W-1:0]  sum9;
        logic [LEN_W-1:0]  n9;
        logic [LEN_W-1:0]  g9;
        logic [LEN_W:0]    f10;
        logic [LEN_W:0]    hs10;
        logic [HELD_W:0]   hsum;
        logic [2:0]        status;
        logic [7:0]        grant;
        logic [7:0]        start;

        w_next      = w_reg;
        u_next      = u_reg;
        h_next      = h_reg;
        free_next   = free_reg;
        held_next   = held_reg;
        unread_next = unread_cur;
        wr_en       = 1'b0;
        burst       = '0;
        status      = STAT_OK;
        grant       = '0;
        start       = '0;
        sum9        = '0;
        n9          = '0;
        g9          = '0;
        f10         = '0;
        hs10        = '0;
        hsum        = '0;

        case (req.mode)
            MODE_WRITE:
            begin
                if (free_reg == '0)
                begin
                    status = STAT_FULL;
                end
                else
                begin
                    wr_en       = 1'b1;
                    sum9        = {1'b0, w_reg} + LEN_W'(1);
                    w_next      = (sum9 >= s_reg) ? '0 : sum9[PTR_W-1:0];
                    free_next   = free_reg - 8'd1;
                    grant       = 8'd1;
                    unread_next = unread_of(w_next, u_reg, s_reg);
                end
            end
            MODE_COPY:
            begin
                n9 = {1'b0, unread_cur};
                if (req.length < n9)
                begin
                    n9 = req.length;
                end
                if (n9 > BURST_MAX)
                begin
                    n9 = BURST_MAX;
                end
                sum9        = {1'b0, u_reg} + n9;
                u_next      = (sum9 >= s_reg) ? 8'(sum9 - s_reg) : sum9[PTR_W-1:0];
                h_next      = u_next;
                f10         = {2'b0, free_reg} + {1'b0, n9};
                free_next   = (f10 > {2'b0, s_m1}) ? s_m1 : f10[7:0];
                grant       = n9[7:0];
                burst       = n9[7:0];
                unread_next = unread_cur - n9[7:0];
            end
            MODE_HOLD:
            begin
                start = u_reg;
                if (w_reg >= u_reg)
                begin
                    g9 = {1'b0, w_reg} - {1'b0, u_reg};
                    if (req.length != '0 && req.length < g9)
                    begin
                        g9 = req.length;
                    end
                    u_next = 8'({1'b0, u_reg} + g9);
                end
                else
                begin
                    g9 = s_reg - {1'b0, u_reg};
                    if (req.length != '0 && g9 > req.length)
                    begin
                        g9     = req.length;
                        u_next = 8'({1'b0, u_reg} + g9);
                    end
                    else
                    begin
                        // grant runs to the end of the ring
                        u_next = '0;
                    end
                end
                hsum        = {1'b0, held_reg} + {1'b0, g9};
                held_next   = (hsum > HELD_SAT) ? HELD_SAT[HELD_W-1:0] : hsum[HELD_W-1:0];
                grant       = g9[7:0];
                unread_next = unread_cur - g9[7:0];
            end
            MODE_RETURN:
            begin
                if (req.offset == h_reg)
                begin
                    hs10   = {2'b0, h_reg} + {1'b0, req.length};
                    h_next = (hs10 >= {1'b0, s_reg}) ? '0 : hs10[PTR_W-1:0];
                    f10    = {2'b0, free_reg} + {1'b0, req.length};
                    if (f10 >= {1'b0, s_reg})
                    begin
                        free_next = s_m1;
                        status    = STAT_CLAMP;
                    end
                    else
                    begin
                        free_next = f10[7:0];
                    end
                end
                else
                begin
                    status = STAT_ORDER;
                end
                if (held_reg < req.length)
                begin
                    held_next = '0;
                    status    = STAT_UNDER;
                end
                else
                begin
                    held_next = held_reg - req.length;
                end
                // nothing held: hold pointer catches up and free space is rebuilt
                if (held_next == '0)
                begin
                    h_next    = u_reg;
                    free_next = s_m1 - unread_cur;
                end
            end
            default:
            begin
                status = STAT_OK;
            end
        endcase

        rsp_next.read_data    = '0;
        rsp_next.grant_count  = grant;
        rsp_next.region_start = start;
        rsp_next.free_count   = free_next;
        rsp_next.unread_count = unread_next;
        rsp_next.status       = status;
        rsp_next.last         = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg    <= S_MAX;
            w_reg    <= '0;
            u_reg    <= '0;
            h_reg    <= '0;
            free_reg <= 8'(S_MAX - LEN_W'(1));
            held_reg <= '0;
        end
        else if (cfg_we)
        begin
            s_reg    <= s_cfg;
            w_reg    <= '0;
            u_reg    <= '0;
            h_reg    <= '0;
            free_reg <= 8'(s_cfg - LEN_W'(1));
            held_reg <= '0;
        end
        else if (accept)
        begin
            w_reg    <= w_next;
            u_reg    <= u_next;
            h_reg    <= h_next;
            free_reg <= free_next;
            held_reg <= held_next;
        end
    end

    assign stat.wr_en    = wr_en;
    assign stat.wr_ptr   = w_reg;
    assign stat.rd_ptr   = u_reg;
    assign stat.ring_len = s_reg;
    assign stat.burst    = burst;

endmodule

`default_nettype wire
